### hw/rtl/grbt_pkg.sv
`timescale 1ns / 1ps

package grbt_pkg;

  // Pixel geometry of one tile row.
  localparam int unsigned PIX_PER_ROW = 8;
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned ROW_W       = PIX_PER_ROW * NIB_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_LUT = 1'b0,
    CFG_BIT_DEPTH = 1'b1
  } cfg_idx_t;

  // Glyph source depth codes. The unused code behaves as four bits per pixel.
  typedef enum logic [1:0] {
    MODE_1BPP = 2'd0,
    MODE_2BPP = 2'd1,
    MODE_4BPP = 2'd2,
    MODE_RSVD = 2'd3
  } depth_mode_t;

  localparam logic [3:0] MAX_WIDTH = 4'd8;
  localparam logic [3:0] MAX_START = 4'd7;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] color_lut;
    depth_mode_t           bit_depth_mode;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] glyph_row;
    logic [3:0]       glyph_width;
    logic [3:0]       start_pixel;
    logic [ROW_W-1:0] dest_row;
    logic [ROW_W-1:0] spill_row;
    logic             spill_present;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0] new_dest_row;
    logic [ROW_W-1:0] new_spill_row;
    logic             spill_written;
    logic             tiles_advanced;
  } out_item_t;

endpackage

### hw/rtl/grbt_if.sv
`timescale 1ns / 1ps

// Input channel: one glyph row with its destination and spill rows.
interface grbt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] glyph_row;
  logic [3:0]  glyph_width;
  logic [3:0]  start_pixel;
  logic [31:0] dest_row;
  logic [31:0] spill_row;
  logic        spill_present;

  modport source (
    output valid, glyph_row, glyph_width, start_pixel, dest_row, spill_row,
           spill_present,
    input  ready
  );
  modport sink (
    input  valid, glyph_row, glyph_width, start_pixel, dest_row, spill_row,
           spill_present,
    output ready
  );
endinterface

// Result channel: the blended rows.
interface grbt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_dest_row;
  logic [31:0] new_spill_row;
  logic        spill_written;
  logic        tiles_advanced;

  modport source (
    output valid, new_dest_row, new_spill_row, spill_written, tiles_advanced,
    input  ready
  );
  modport sink (
    input  valid, new_dest_row, new_spill_row, spill_written, tiles_advanced,
    output ready
  );
endinterface

### hw/rtl/grbt_blend.sv
`timescale 1ns / 1ps

// Expands one glyph row through the color table and merges it into the
// destination and spill rows.
module grbt_blend (
  input  grbt_pkg::in_item_t  item,
  input  grbt_pkg::cfg_t      cfg,
  output grbt_pkg::out_item_t result
);

  logic [3:0]                  width_sat;
  logic [2:0]                  start_sat;
  logic [3:0]                  end_col;
  logic [3:0]                  n_pix;
  logic [grbt_pkg::ROW_W-1:0]  val;
  logic [2*grbt_pkg::ROW_W-1:0] placed;
  logic [grbt_pkg::ROW_W-1:0]  mask1;
  logic [grbt_pkg::ROW_W-1:0]  mask2;
  logic                        do_spill;

  always_comb begin
    logic [3:0] px;
    logic [3:0] spill_end;

    width_sat = (item.glyph_width > grbt_pkg::MAX_WIDTH) ? grbt_pkg::MAX_WIDTH
                                                         : item.glyph_width;
    start_sat = (item.start_pixel > grbt_pkg::MAX_START) ? grbt_pkg::MAX_START[2:0]
                                                         : item.start_pixel[2:0];
    end_col   = {1'b0, start_sat} + width_sat;

    // One-bit glyphs of width three expand a fourth pixel.
    n_pix = ((cfg.bit_depth_mode == grbt_pkg::MODE_1BPP) && (width_sat == 4'd3))
          ? 4'd4 : width_sat;

    val = '0;
    for (int p = 0; p < grbt_pkg::PIX_PER_ROW; p++) begin
      case (cfg.bit_depth_mode)
        grbt_pkg::MODE_1BPP: px = {3'b000, item.glyph_row[7-p]};
        grbt_pkg::MODE_2BPP: px = {2'b00, item.glyph_row[2*p +: 2]};
        default:             px = item.glyph_row[4*p +: 4];
      endcase
      if (4'(p) < n_pix) begin
        val[4*p +: 4] = cfg.color_lut[{px, 2'b00} +: 4];
      end
    end

    // The upper half of the placed word is what runs past column seven.
    placed = {{grbt_pkg::ROW_W{1'b0}}, val} << {start_sat, 2'b00};

    spill_end = end_col - grbt_pkg::MAX_WIDTH;
    for (int i = 0; i < grbt_pkg::PIX_PER_ROW; i++) begin
      mask1[4*i +: 4] = {4{(4'(i) < {1'b0, start_sat}) || (4'(i) >= end_col)}};
      mask2[4*i +: 4] = {4{4'(i) >= spill_end}};
    end

    do_spill = item.spill_present && (end_col > grbt_pkg::MAX_WIDTH)
             && (start_sat != 3'd0);

    if (item.glyph_width == 4'd0) begin
      result.new_dest_row   = item.dest_row;
      result.new_spill_row  = item.spill_row;
      result.spill_written  = 1'b0;
      result.tiles_advanced = item.start_pixel[3];
    end else begin
      result.new_dest_row   = (item.dest_row & mask1) | placed[grbt_pkg::ROW_W-1:0];
      result.new_spill_row  = do_spill
                            ? ((item.spill_row & mask2)
                               | placed[2*grbt_pkg::ROW_W-1:grbt_pkg::ROW_W])
                            : item.spill_row;
      result.spill_written  = do_spill;
      result.tiles_advanced = end_col[3];
    end
  end

endmodule

### hw/rtl/glyph_row_blend_into_tile.sv
`timescale 1ns / 1ps

// Channel   Direction  Contents
// in_ch     in         glyph_row, glyph_width, start_pixel, dest_row, spill_row,
//                      spill_present
// out_ch    out        new_dest_row, new_spill_row, spill_written, tiles_advanced
// cfg_*     in         write enable, register index, 64-bit write data
//
// One row is taken per cycle while out_ch does not stall. A transfer on in_ch
// lands in the input register; the blend is computed combinationally from it
// and held in the result register, which offers it on out_ch. rst_n clears the
// valid flags and loads the table with zero and the depth with 4bpp. When
// out_ch stalls, the two stages fill and then in_ch ready drops.
module glyph_row_blend_into_tile (
  input  logic                               clk,
  input  logic                               rst_n,
  grbt_in_if.sink                            in_ch,
  grbt_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [grbt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [grbt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  grbt_pkg::cfg_t      cfg_r;
  grbt_pkg::in_item_t  in_r;
  grbt_pkg::out_item_t out_r;
  grbt_pkg::out_item_t blend_nxt;
  grbt_pkg::in_item_t  in_item;
  logic                in_vld_r;
  logic                out_vld_r;
  logic                out_adv;
  logic                in_adv;

  // Configuration registers. Writes must arrive only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.color_lut      <= '0;
      cfg_r.bit_depth_mode <= grbt_pkg::MODE_4BPP;
    end else if (cfg_we) begin
      case (grbt_pkg::cfg_idx_t'(cfg_index))
        grbt_pkg::CFG_COLOR_LUT: cfg_r.color_lut <= cfg_wdata;
        grbt_pkg::CFG_BIT_DEPTH:
          cfg_r.bit_depth_mode <= grbt_pkg::depth_mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // The result register moves when it is empty or its content is taken;
  // the input register moves when it is empty or hands over to the result.
  assign out_adv     = !out_vld_r || out_ch.ready;
  assign in_adv      = !in_vld_r || out_adv;
  assign in_ch.ready = in_adv;

  assign in_item.glyph_row     = in_ch.glyph_row;
  assign in_item.glyph_width   = in_ch.glyph_width;
  assign in_item.start_pixel   = in_ch.start_pixel;
  assign in_item.dest_row      = in_ch.dest_row;
  assign in_item.spill_row     = in_ch.spill_row;
  assign in_item.spill_present = in_ch.spill_present;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_adv) begin
        in_vld_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_ch.valid) begin
      in_r <= in_item;
    end
    if (out_adv && in_vld_r) begin
      out_r <= blend_nxt;
    end
  end

  grbt_blend u_blend (
    .item   (in_r),
    .cfg    (cfg_r),
    .result (blend_nxt)
  );

  assign out_ch.valid          = out_vld_r;
  assign out_ch.new_dest_row   = out_r.new_dest_row;
  assign out_ch.new_spill_row  = out_r.new_spill_row;
  assign out_ch.spill_written  = out_r.spill_written;
  assign out_ch.tiles_advanced = out_r.tiles_advanced;

endmodule
